[design/pfs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types and constants of the packed field store.
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int STORE_BYTES_DEF      = 4096;
  localparam int MAX_ELEMENT_BITS_DEF = 32;

  localparam int NUM_BANKS = 8;   // one bank per byte lane of the 64-bit window
  localparam int IDX_W     = 15;  // element index width
  localparam int EBITS_W   = 6;   // element width register
  localparam int FB_W      = IDX_W + EBITS_W;  // first bit position
  localparam int EB_W      = FB_W + 1;         // exclusive end bit position
  localparam int LB_W      = EB_W - 3;         // byte position
  localparam int WIN_W     = 64;
  localparam int VAL_W     = 32;

  localparam logic [7:0] BYTE_MASK = 8'hFF;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] element_index;
    logic [VAL_W-1:0] wr_data;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic             out_of_range;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic clear_en;   // write one zero row into every bank
    logic load_item;  // capture the accepted word and its first bit
    logic rd_en;      // read the window rows
    logic finish;     // merge, write back and load the result register
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_last;
    logic slot_free;
  } dp_stat_t;

endpackage
`default_nettype wire

[design/pfs_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pfs_ram
// Single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module pfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[design/pfs_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pfs_ctrl
// Sequencer of the packed field store: clearing pass, then address and
// read/merge phases for each word.
// ----------------------------------------------------------------------------
module pfs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire pfs_pkg::dp_stat_t stat_i,
  output pfs_pkg::ctrl_cmd_t     cmd_o
);
  import pfs_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_ADDR  = 2'd2;
  localparam logic [1:0] S_RD    = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (stat_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_RD;
      end
      S_RD: begin
        // The read data holds until the result register has room.
        if (stat_i.slot_free) begin
          cmd_o.finish = 1'b1;
          in_ready_o   = 1'b1;
          state_d      = in_valid_i ? S_ADDR : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    cmd_o.load_item = in_valid_i && in_ready_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_ready_o)
    else $error("word accepted during the clearing pass");

  a_load_then_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_item |=> (state_q == S_ADDR))
    else $error("accepted word did not enter the address phase");

  a_addr_then_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADDR) |=> (state_q == S_RD))
    else $error("address phase not followed by read phase");

endmodule
`default_nettype wire

[design/pfs_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pfs_dpath
// Datapath of the packed field store: element width register, eight byte
// banks, window gather and merge, and the result register.
// ----------------------------------------------------------------------------
module pfs_dpath #(
  parameter int STORE_BYTES      = pfs_pkg::STORE_BYTES_DEF,
  parameter int MAX_ELEMENT_BITS = pfs_pkg::MAX_ELEMENT_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [pfs_pkg::EBITS_W-1:0] cfg_wdata_i,
  input  wire pfs_pkg::in_item_t           in_data_i,
  input  wire pfs_pkg::ctrl_cmd_t          cmd_i,
  output pfs_pkg::dp_stat_t                stat_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output pfs_pkg::out_item_t               out_data_o
);
  import pfs_pkg::*;

  localparam int ROWS = (STORE_BYTES + NUM_BANKS - 1) / NUM_BANKS;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [EBITS_W-1:0] ebits_q;
  logic [EBITS_W-1:0] width_act;

  logic               mode_q;
  logic [VAL_W-1:0]   wval_q;
  logic [EBITS_W-1:0] w_q;
  logic [FB_W-1:0]    first_bit_q;

  logic [RW-1:0]      clr_cnt_q;

  logic [EB_W-1:0]    end_bit;
  logic [LB_W-1:0]    first_byte, last_byte;
  logic [2:0]         byte_off, bit_off, nb_m1;
  logic [LB_W-4:0]    row_base;
  logic               zero_w, oor;

  logic [31:0]        row_ext   [NUM_BANKS];
  logic [RW-1:0]      bank_addr [NUM_BANKS];
  logic [2:0]         bank_lane [NUM_BANKS];
  logic               bank_we   [NUM_BANKS];
  logic [7:0]         bank_wd   [NUM_BANKS];
  logic [7:0]         bank_rd   [NUM_BANKS];

  logic [WIN_W-1:0]   win, new_win, emask, placed;
  logic [VAL_W-1:0]   rd_val;
  logic               wr_fire;

  logic               out_valid_q;
  out_item_t          out_q;

  assign width_act = (ebits_q > EBITS_W'(MAX_ELEMENT_BITS))
                   ? EBITS_W'(MAX_ELEMENT_BITS) : ebits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ebits_q <= EBITS_W'(1);
    end else if (cfg_we_i) begin
      ebits_q <= cfg_wdata_i;
    end
  end

  // The element position is multiplied out as the word is taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q      <= in_data_i.mode;
      wval_q      <= in_data_i.wr_data;
      w_q         <= width_act;
      first_bit_q <= FB_W'(in_data_i.element_index) * FB_W'(width_act);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_en) begin
      clr_cnt_q <= clr_cnt_q + RW'(1);
    end
  end

  assign stat_o.clear_last = (clr_cnt_q == RW'(ROWS - 1));
  assign stat_o.slot_free  = !out_valid_q || out_ready_i;

  // Element geometry.
  assign end_bit    = EB_W'(first_bit_q) + EB_W'(w_q);
  assign first_byte = LB_W'(first_bit_q >> 3);
  assign last_byte  = LB_W'((end_bit - EB_W'(1)) >> 3);
  assign byte_off   = first_byte[2:0];
  assign bit_off    = first_bit_q[2:0];
  assign row_base   = first_byte[LB_W-1:3];
  assign nb_m1      = 3'(last_byte - first_byte);
  assign zero_w     = (w_q == '0);
  assign oor        = !zero_w && (32'(last_byte) >= 32'(STORE_BYTES));

  // Window gather: lane k of the window is bank (byte_off + k) mod 8.
  always_comb begin
    for (int k = 0; k < NUM_BANKS; k++) begin
      win[8*k +: 8] = bank_rd[3'(byte_off + 3'(k))];
    end
  end

  assign emask   = (WIN_W'(1) << w_q) - WIN_W'(1);
  assign placed  = emask << bit_off;
  assign rd_val  = VAL_W'((win >> bit_off) & emask);
  assign new_win = (win & ~placed) | ((WIN_W'(wval_q) & emask) << bit_off);
  assign wr_fire = cmd_i.finish && (mode_q == MODE_WRITE) && !zero_w && !oor;

  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      // Banks below the start lane hold bytes of the following row.
      row_ext[b]   = 32'(row_base) + ((3'(b) < byte_off) ? 32'd1 : 32'd0);
      bank_lane[b] = 3'(3'(b) - byte_off);
      if (cmd_i.clear_en) begin
        bank_addr[b] = clr_cnt_q;
        bank_we[b]   = 1'b1;
        bank_wd[b]   = '0;
      end else begin
        bank_addr[b] = (row_ext[b] >= 32'(ROWS)) ? '0 : row_ext[b][RW-1:0];
        bank_we[b]   = wr_fire && (bank_lane[b] <= nb_m1);
        bank_wd[b]   = new_win[{bank_lane[b], 3'b000} +: 8] & BYTE_MASK;
      end
    end
  end

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    pfs_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[g]),
      .re_i    (cmd_i.rd_en),
      .addr_i  (bank_addr[g]),
      .wdata_i (bank_wd[g]),
      .rdata_o (bank_rd[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.read_value   <= ((mode_q == MODE_READ) && !zero_w && !oor) ? rd_val : '0;
      out_q.out_of_range <= oor;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_finish_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while still waiting");

  a_no_write_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_fire && !cmd_i.clear_en) |-> (!oor && !zero_w))
    else $error("store written for an element outside the store");

  a_clear_not_mixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_en |-> (!cmd_i.load_item && !cmd_i.finish && !cmd_i.rd_en))
    else $error("item handled during the clearing pass");

endmodule
`default_nettype wire

[design/packed_field_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// packed_field_store
// Byte store holding tightly packed elements of a programmable bit width,
// least significant bit first, with element read and write operations.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (mode, element_index, wr_data) arrive on a valid/ready
//   channel; each produces exactly one output word (read_value, out_of_range)
//   on a second valid/ready channel. The element width is written through
//   cfg_we_i/cfg_wdata_i while the block is idle; widths above
//   MAX_ELEMENT_BITS are clamped, and a width of zero reads as 0 and never
//   writes.
//   The store is eight byte-wide banks, so any element window of up to eight
//   bytes is read from all banks at once and written back in the merge phase.
//   An accepted word passes an address phase, then a read/merge/write-back
//   phase that loads its result into the output register. The next word can
//   be taken during that read/merge phase while the receiver keeps up.
//   After reset a clearing pass zeroes one row of all banks per cycle over
//   ceil(STORE_BYTES/8) rows (512 by default); no word is accepted until it
//   ends. A stalled receiver holds the result in its register; the block may
//   still take one more word, then waits with it in the merge phase and takes
//   the next word once the result leaves.
// ----------------------------------------------------------------------------
module packed_field_store #(
  parameter int STORE_BYTES      = pfs_pkg::STORE_BYTES_DEF,
  parameter int MAX_ELEMENT_BITS = pfs_pkg::MAX_ELEMENT_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [pfs_pkg::EBITS_W-1:0] cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire pfs_pkg::in_item_t           in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output pfs_pkg::out_item_t               out_data_o
);
  import pfs_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  pfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pfs_dpath #(
    .STORE_BYTES      (STORE_BYTES),
    .MAX_ELEMENT_BITS (MAX_ELEMENT_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
